[rtl/sfpr_pkg.sv]
// Shared types, constants and register map of the serial frame parser and router.
package sfpr_pkg;

	localparam int NUM_DEVICES = 4;
	localparam int NUM_SLOTS   = 4;
	localparam int FIFO_DEPTH  = 4;
	localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

	localparam logic [7:0] BROADCAST_ADDR = 8'hFF;
	localparam logic [7:0] HOST_ADDR      = 8'h00;

	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;
	localparam int IN_DATA_W  = 8;
	localparam int OUT_DATA_W = 64;

	localparam logic [2:0] POS_HUNT  = 3'd0;
	localparam logic [2:0] POS_DEST  = 3'd1;
	localparam logic [2:0] POS_CHECK = 3'd7;

	localparam logic [3:0] MASK_ALL = 4'((1 << NUM_DEVICES) - 1);

	typedef enum logic [2:0] {
		REG_START_BYTE = 3'd0,
		REG_DEVICE_ID0 = 3'd1,
		REG_DEVICE_ID1 = 3'd2,
		REG_DEVICE_ID2 = 3'd3,
		REG_DEVICE_ID3 = 3'd4
	} reg_index_t;

	typedef enum logic [1:0] {
		ROUTE_BCAST = 2'd0,
		ROUTE_REPLY = 2'd1,
		ROUTE_LOCAL = 2'd2,
		ROUTE_FWD   = 2'd3
	} route_t;

	typedef logic [NUM_SLOTS-1:0][7:0] id_array_t;

	// One completed frame as handed from the parser to the router.
	typedef struct packed {
		logic       port;
		logic [7:0] check_byte;
		logic [7:0] argument_byte;
		logic [7:0] command_byte;
		logic [7:0] frame_size;
		logic [7:0] link_ctrl;
		logic [7:0] src_addr;
		logic [7:0] dest_addr;
	} frame_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_status_t;

endpackage

[rtl/serial_frame_parser_router.sv]
// Top level of the serial frame parser and router with its register file.
// A frame enters the queue with the beat that carries its check byte, and
// m_axis_tvalid rises as it moves to the output register, if that is free.
// Throughput: one received byte per cycle; s_axis_tready only drops while the
// 4-entry queue is full. The router drains one frame per cycle unless stalled.
// Reset (arst_n, asynchronous): both assemblers hunt for a start byte, the
// queue and output register are empty, and registers take their defaults.
module serial_frame_parser_router (
	input  logic        clk,
	input  logic        arst_n,
	// APB-style configuration port.
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [sfpr_pkg::PADDR_W-1:0]  paddr,
	input  logic [sfpr_pkg::PDATA_W-1:0]  pwdata,
	output logic [sfpr_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready,
	// Received byte stream.
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [sfpr_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // [7:0] rx_byte
	input  logic                              s_axis_tuser,  // [0] rx_port
	// Completed frame stream.
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// [7:0] dest_addr, [15:8] src_addr, [23:16] link_ctrl, [31:24] frame_size,
	// [39:32] command_byte, [47:40] argument_byte, [55:48] check_byte,
	// [57:56] route, [61:58] device_mask, [63:62] zero
	output logic [sfpr_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	output logic                              m_axis_tuser   // [0] from_port
);
	import sfpr_pkg::*;

	logic [7:0]   start_byte_q;
	id_array_t    device_id_q;
	logic         cfg_write;
	reg_index_t   reg_idx;
	logic         in_beat;
	logic         push;
	frame_t       push_frame;
	frame_t       head;
	fifo_status_t fifo_st;
	logic         pop;
	frame_t       out_frame_q;
	route_t       out_route_q;
	logic [3:0]   out_mask_q;

	// Register file. Writes land on the access cycle; unknown addresses are ignored.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign reg_idx   = reg_index_t'(paddr[PADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q   <= 8'h7E;
			device_id_q[0] <= 8'h21;
			device_id_q[1] <= 8'h22;
			device_id_q[2] <= 8'h23;
			device_id_q[3] <= 8'h24;
		end else if (cfg_write) begin
			unique case (reg_idx)
				REG_START_BYTE: start_byte_q   <= pwdata[7:0];
				REG_DEVICE_ID0: device_id_q[0] <= pwdata[7:0];
				REG_DEVICE_ID1: device_id_q[1] <= pwdata[7:0];
				REG_DEVICE_ID2: device_id_q[2] <= pwdata[7:0];
				REG_DEVICE_ID3: device_id_q[3] <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_START_BYTE: prdata = PDATA_W'(start_byte_q);
			REG_DEVICE_ID0: prdata = PDATA_W'(device_id_q[0]);
			REG_DEVICE_ID1: prdata = PDATA_W'(device_id_q[1]);
			REG_DEVICE_ID2: prdata = PDATA_W'(device_id_q[2]);
			REG_DEVICE_ID3: prdata = PDATA_W'(device_id_q[3]);
			default:        prdata = '0;
		endcase
	end

	// The parser takes a beat whenever the queue has room, so it keeps
	// assembling while the router waits on the master side.
	assign s_axis_tready = !fifo_st.full;
	assign in_beat       = s_axis_tvalid && s_axis_tready;

	sfpr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_beat    (in_beat),
		.rx_port    (s_axis_tuser),
		.rx_byte    (s_axis_tdata),
		.start_byte (start_byte_q),
		.push       (push),
		.push_frame (push_frame)
	);

	sfpr_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_frame (push_frame),
		.pop        (pop),
		.head       (head),
		.status     (fifo_st)
	);

	sfpr_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.status      (fifo_st),
		.device_id   (device_id_q),
		.pop         (pop),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_frame_q (out_frame_q),
		.out_route_q (out_route_q),
		.out_mask_q  (out_mask_q)
	);

	assign m_axis_tuser = out_frame_q.port;
	assign m_axis_tdata = {2'b00, out_mask_q, out_route_q,
		out_frame_q.check_byte, out_frame_q.argument_byte,
		out_frame_q.command_byte, out_frame_q.frame_size,
		out_frame_q.link_ctrl, out_frame_q.src_addr, out_frame_q.dest_addr};

	// A completed frame is never offered to a full queue.
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && fifo_st.full))
		else $error("frame pushed into a full queue");

	// Replies and forward-only frames go to no local slot.
	a_mask_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (out_route_q == ROUTE_REPLY || out_route_q == ROUTE_FWD)
		|-> out_mask_q == '0)
		else $error("device mask set on a non-local route");

	// Local delivery names at least one slot.
	a_local_has_slot: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && out_route_q == ROUTE_LOCAL |-> out_mask_q != '0)
		else $error("local route with empty device mask");

	// Only the broadcast destination yields the broadcast route.
	a_bcast_dest: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && out_route_q == ROUTE_BCAST
		|-> out_frame_q.dest_addr == BROADCAST_ADDR)
		else $error("broadcast route on a unicast destination");

	// A pop from the queue always fills the output register on the next edge.
	a_pop_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> m_axis_tvalid)
		else $error("popped frame lost before the output");

endmodule

[rtl/sfpr_front.sv]
// Per-port frame assemblers that turn received bytes into completed frames.
module sfpr_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_beat,
	input  logic                  rx_port,
	input  logic [7:0]            rx_byte,
	input  logic [7:0]            start_byte,
	output logic                  push,
	output sfpr_pkg::frame_t      push_frame
);
	import sfpr_pkg::*;

	logic [1:0][2:0]      pos_q;
	logic [1:0][5:0][7:0] fields_q;
	logic [2:0]           pos;
	logic [2:0]           field_idx;

	assign pos       = pos_q[rx_port];
	assign field_idx = pos - 3'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (in_beat) begin
			priority if (pos == POS_HUNT) begin
				if (rx_byte == start_byte) pos_q[rx_port] <= POS_DEST;
			end else if (pos == POS_DEST && rx_port && rx_byte != HOST_ADDR) begin
				// Onward frames not addressed to the host are dropped.
				pos_q[rx_port] <= POS_HUNT;
			end else if (pos == POS_CHECK) begin
				pos_q[rx_port] <= POS_HUNT;
			end else begin
				pos_q[rx_port] <= pos + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat && pos != POS_HUNT && pos != POS_CHECK)
			fields_q[rx_port][field_idx] <= rx_byte;
	end

	assign push = in_beat && pos == POS_CHECK;

	always_comb begin
		push_frame.port          = rx_port;
		push_frame.dest_addr     = fields_q[rx_port][0];
		push_frame.src_addr      = fields_q[rx_port][1];
		push_frame.link_ctrl     = fields_q[rx_port][2];
		push_frame.frame_size    = fields_q[rx_port][3];
		push_frame.command_byte  = fields_q[rx_port][4];
		push_frame.argument_byte = fields_q[rx_port][5];
		push_frame.check_byte    = rx_byte;
	end

endmodule

[rtl/sfpr_fifo.sv]
// Short frame queue between the parser and the router.
module sfpr_fifo (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  sfpr_pkg::frame_t       push_frame,
	input  logic                   pop,
	output sfpr_pkg::frame_t       head,
	output sfpr_pkg::fifo_status_t status
);
	import sfpr_pkg::*;

	frame_t                 mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0]  wr_ptr_q;
	logic [FIFO_PTR_W-1:0]  rd_ptr_q;
	logic [FIFO_CNT_W-1:0]  count_q;
	logic                   do_push;
	logic                   do_pop;

	assign status.full  = count_q == FIFO_CNT_W'(FIFO_DEPTH);
	assign status.empty = count_q == '0;
	assign do_push = push && !status.full;
	assign do_pop  = pop && !status.empty;
	assign head    = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_frame;
	end

endmodule

[rtl/sfpr_back.sv]
// Routing decision and output register for completed frames.
module sfpr_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  sfpr_pkg::frame_t       head,
	input  sfpr_pkg::fifo_status_t status,
	input  sfpr_pkg::id_array_t    device_id,
	output logic                   pop,
	output logic                   out_valid,
	input  logic                   out_ready,
	output sfpr_pkg::frame_t       out_frame_q,
	output sfpr_pkg::route_t       out_route_q,
	output logic [3:0]             out_mask_q
);
	import sfpr_pkg::*;

	logic       valid_q;
	route_t     route;
	logic [3:0] mask;
	logic [3:0] match;

	always_comb begin
		match = '0;
		for (int i = 0; i < NUM_SLOTS; i++)
			if (i < NUM_DEVICES && device_id[i] == head.dest_addr) match[i] = 1'b1;
	end

	always_comb begin
		priority if (head.dest_addr == BROADCAST_ADDR) begin
			route = ROUTE_BCAST;
			mask  = MASK_ALL;
		end else if (head.dest_addr == HOST_ADDR) begin
			route = ROUTE_REPLY;
			mask  = '0;
		end else if (match != '0) begin
			route = ROUTE_LOCAL;
			mask  = match;
		end else begin
			route = ROUTE_FWD;
			mask  = '0;
		end
	end

	assign pop       = !status.empty && (!valid_q || out_ready);
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || out_ready) begin
			valid_q <= !status.empty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_frame_q <= head;
			out_route_q <= route;
			out_mask_q  <= mask;
		end
	end

endmodule
